/* rtl/a85_pkg.sv */
`default_nettype none
package a85_pkg;

  // Default depth of the queue between the front and the back.
  localparam int QDEPTH_DEF = 4;

  // Front phases.
  localparam logic [2:0] PH_LT    = 3'd0;
  localparam logic [2:0] PH_TILDE = 3'd1;
  localparam logic [2:0] PH_BODY  = 3'd2;
  localparam logic [2:0] PH_GT    = 3'd3;
  localparam logic [2:0] PH_DONE  = 3'd4;
  localparam logic [2:0] PH_ERR   = 3'd5;

  // Result status codes.
  localparam logic [2:0] ST_DATA  = 3'd0;
  localparam logic [2:0] ST_DONE  = 3'd1;
  localparam logic [2:0] ST_START = 3'd2;
  localparam logic [2:0] ST_END   = 3'd3;
  localparam logic [2:0] ST_CHAR  = 3'd4;
  localparam logic [2:0] ST_OVF   = 3'd5;

  // Characters with a meaning of their own.
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_DIG_LO = 8'd33;
  localparam logic [7:0] CH_DIG_HI = 8'd117;

  // Powers of 85 used to pad a short tail group.
  localparam logic [19:0] P85_1 = 20'd85;
  localparam logic [19:0] P85_2 = 20'd7225;
  localparam logic [19:0] P85_3 = 20'd614125;

  // One unit of work for the back: data bytes, then an optional status.
  typedef struct packed {
    logic [31:0] value;
    logic [2:0]  nbytes;
    logic        has_status;
    logic [2:0]  status;
  } job_t;

endpackage
`default_nettype wire

/* rtl/a85_front.sv */
`default_nettype none
module a85_front
  import a85_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [7:0] in_char,
  input  wire logic       in_eos,
  input  wire logic       q_full,
  output logic            push,
  output job_t            job
);

  logic [2:0]  phase_r, phase_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        ovf_r, ovf_nxt;

  logic        accept;
  logic        is_space;
  logic        is_digit;
  logic [7:0]  digit8;
  logic [38:0] grp_v;
  logic        grp_hi;
  logic [19:0] tail_mul;
  logic [52:0] tail_v;
  logic        tail_hi;

  assign accept = in_valid && !q_full;

  // Character classes.
  assign is_space = (in_char == 8'h20) || (in_char == 8'h09) || (in_char == 8'h0A) ||
                    (in_char == 8'h0D) || (in_char == 8'h0B) || (in_char == 8'h0C);
  assign is_digit = (in_char >= CH_DIG_LO) && (in_char <= CH_DIG_HI);
  assign digit8   = in_char - CH_DIG_LO;

  // Next group value: one constant multiply by 85 and an add.
  assign grp_v  = {7'd0, acc_r} * 39'd85 + {32'd0, digit8[6:0]};
  assign grp_hi = (grp_v[38:32] != 7'd0);

  // A tail group of n digits padded with 84s equals (acc + 1) * 85^(5-n) - 1.
  always_comb begin
    unique case (cnt_r)
      3'd2:    tail_mul = P85_3;
      3'd3:    tail_mul = P85_2;
      3'd4:    tail_mul = P85_1;
      default: tail_mul = 20'd1;
    endcase
  end
  assign tail_v  = {21'd0, acc_r} * {33'd0, tail_mul} + {33'd0, tail_mul} - 53'd1;
  assign tail_hi = (tail_v[52:32] != 21'd0);

  // Phase walk and work for the back.
  always_comb begin
    phase_nxt       = phase_r;
    acc_nxt         = acc_r;
    cnt_nxt         = cnt_r;
    ovf_nxt         = ovf_r;
    push            = 1'b0;
    job.value       = 32'd0;
    job.nbytes      = 3'd0;
    job.has_status  = 1'b1;
    job.status      = ST_DATA;
    if (accept) begin
      if (in_eos) begin
        phase_nxt = PH_LT;
        acc_nxt   = 32'd0;
        cnt_nxt   = 3'd0;
        ovf_nxt   = 1'b0;
        if (phase_r == PH_LT || phase_r == PH_TILDE) begin
          push       = 1'b1;
          job.status = ST_START;
        end else if (phase_r == PH_BODY || phase_r == PH_GT) begin
          push       = 1'b1;
          job.status = ST_END;
        end
      end else begin
        unique case (phase_r)
          PH_LT: begin
            if (in_char == CH_LT) begin
              phase_nxt = PH_TILDE;
            end else begin
              phase_nxt  = PH_ERR;
              push       = 1'b1;
              job.status = ST_START;
            end
          end
          PH_TILDE: begin
            acc_nxt = 32'd0;
            cnt_nxt = 3'd0;
            ovf_nxt = 1'b0;
            if (in_char == CH_TILDE) begin
              phase_nxt = PH_BODY;
            end else begin
              phase_nxt  = PH_ERR;
              push       = 1'b1;
              job.status = ST_START;
            end
          end
          PH_BODY: begin
            if (is_space) begin
              phase_nxt = PH_BODY;
            end else if (in_char == CH_TILDE) begin
              phase_nxt = PH_GT;
            end else if (!is_digit) begin
              phase_nxt  = PH_ERR;
              acc_nxt    = 32'd0;
              cnt_nxt    = 3'd0;
              ovf_nxt    = 1'b0;
              push       = 1'b1;
              job.status = ST_CHAR;
            end else if (cnt_r < 3'd4) begin
              acc_nxt = grp_v[31:0];
              cnt_nxt = cnt_r + 3'd1;
              ovf_nxt = ovf_r || grp_hi;
            end else begin
              acc_nxt = 32'd0;
              cnt_nxt = 3'd0;
              ovf_nxt = 1'b0;
              push    = 1'b1;
              if (ovf_r || grp_hi) begin
                phase_nxt  = PH_ERR;
                job.status = ST_OVF;
              end else begin
                job.value      = grp_v[31:0];
                job.nbytes     = 3'd4;
                job.has_status = 1'b0;
              end
            end
          end
          PH_GT: begin
            acc_nxt = 32'd0;
            cnt_nxt = 3'd0;
            ovf_nxt = 1'b0;
            push    = 1'b1;
            if (in_char != CH_GT) begin
              phase_nxt  = PH_ERR;
              job.status = ST_END;
            end else if (cnt_r >= 3'd2 && tail_hi) begin
              phase_nxt  = PH_ERR;
              job.status = ST_OVF;
            end else begin
              phase_nxt  = PH_DONE;
              job.status = ST_DONE;
              if (cnt_r >= 3'd2) begin
                job.value  = tail_v[31:0];
                job.nbytes = cnt_r - 3'd1;
              end
            end
          end
          default: begin
            phase_nxt = phase_r;
          end
        endcase
      end
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LT;
      acc_r   <= 32'd0;
      cnt_r   <= 3'd0;
      ovf_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/a85_queue.sv */
`default_nettype none
module a85_queue
  import a85_pkg::*;
#(
  parameter int DEPTH = QDEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_job,
  input  wire logic pop,
  output job_t      head,
  output logic      empty,
  output logic      full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign empty = (count_r == CW'(0));
  assign full  = (count_r == CW'(DEPTH));
  assign head  = mem_r[rd_ptr_r];

  // Storage; entries need no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/a85_back.sv */
`default_nettype none
module a85_back
  import a85_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire job_t       head,
  input  wire logic       empty,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic [2:0]      out_status,
  output logic            out_last
);

  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic [2:0] out_status_r;
  logic       out_last_r;
  logic [1:0] pos_r;

  logic [2:0] total;
  logic       at_last;
  logic       at_status;
  logic       load;
  logic [7:0] sel_byte;

  // Where the current word sits within the head job.
  assign total     = head.nbytes + {2'd0, head.has_status};
  assign at_last   = ({1'b0, pos_r} + 3'd1 == total);
  assign at_status = head.has_status && ({1'b0, pos_r} == head.nbytes);
  assign load      = !empty && (!out_valid_r || !out_stall);
  assign pop       = load && at_last;

  // Big-endian byte pick.
  always_comb begin
    unique case (pos_r)
      2'd0: sel_byte = head.value[31:24];
      2'd1: sel_byte = head.value[23:16];
      2'd2: sel_byte = head.value[15:8];
      2'd3: sel_byte = head.value[7:0];
    endcase
  end

  // Output register and word position.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pos_r       <= 2'd0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        pos_r       <= at_last ? 2'd0 : pos_r + 2'd1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r   <= at_status ? 8'd0 : sel_byte;
      out_status_r <= at_status ? head.status : ST_DATA;
      out_last_r   <= at_last;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_byte   = out_byte_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

endmodule
`default_nettype wire

/* rtl/ascii85_stream_decoder.sv */
`default_nettype none
// Channel   Direction  Handshake            Word
// in_       input      in_valid/in_stall    in_char, in_end_of_stream
// out_      output     out_valid/out_stall  out_byte, out_status, out_last
//
// One character is accepted per cycle while in_stall is low; a full group of
// five yields four bytes. The back sends one result word per cycle while
// out_stall is low, so a closing mark that flushes up to four words drains
// through the QDEPTH-entry queue and then the output register. in_stall is
// high while the queue is full. Reset is synchronous.
module ascii85_stream_decoder
  import a85_pkg::*;
#(
  parameter int QDEPTH = QDEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_char,
  input  wire logic       in_end_of_stream,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic [2:0]      out_status,
  output logic            out_last
);

  job_t q_in_job;
  job_t q_head;
  logic q_push;
  logic q_pop;
  logic q_empty;
  logic q_full;

  assign in_stall = q_full;

  // Front: checks framing and gathers groups.
  a85_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_char  (in_char),
    .in_eos   (in_end_of_stream),
    .q_full   (q_full),
    .push     (q_push),
    .job      (q_in_job)
  );

  // Queue between front and back.
  a85_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_in_job),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  // Back: sends result words one at a time.
  a85_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .empty      (q_empty),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .out_status (out_status),
    .out_last   (out_last)
  );

endmodule
`default_nettype wire

/* rtl/a85_checker.sv */
`default_nettype none
module a85_checker
  import a85_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_byte,
  input wire logic [2:0] out_status,
  input wire logic       out_last
);

  // A stalled result word holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) &&
    $stable(out_status) && $stable(out_last))
    else $error("stalled result word changed");

  // A status word always closes the results of its character.
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_DATA) |-> out_last)
    else $error("status word without last");

  // A status word carries a zero byte.
  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_DATA) |-> (out_byte == 8'd0))
    else $error("status word with nonzero byte");

  // Reset empties the output.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word right after reset");

endmodule

bind ascii85_stream_decoder a85_checker u_a85_checker (.*);
`default_nettype wire
